[hdl/hgr_pkg.sv]
// Shared types and constants for the HDR gamma encoder with flipped destination index.
// Holds the configuration register map and the elaborated gamma threshold table.
// No dependencies.
`default_nettype none

package hgr_pkg;

   // configuration port geometry
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 13;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 4'd0,
      CSR_IMAGE_HEIGHT = 4'd1
   } csr_index_type;

   // channel formats
   localparam int LEVEL_W = 24;
   localparam int CODE_W  = 8;
   localparam int THR_W   = 17;
   localparam int DEST_OUT_W = 24;

   // threshold entry v: smallest level q with q^5 * 255^11 >= v^11 * 2^80
   typedef logic [255:0][THR_W-1:0] thresh_table_type;

   function automatic thresh_table_type build_thresh();
      thresh_table_type tab;
      logic [175:0] p255;
      logic [175:0] vpow;
      logic [175:0] target;
      logic [175:0] qpow;
      logic [17:0]  lo;
      logic [17:0]  hi;
      logic [17:0]  mid;
      p255 = 176'd1;
      for (int i = 0; i < 11; i++) begin
         p255 = p255 * 176'd255;
      end
      tab[0] = '0;
      for (int v = 1; v < 256; v++) begin
         vpow = 176'd1;
         for (int i = 0; i < 11; i++) begin
            vpow = vpow * 176'(v);
         end
         target = vpow << 80;
         lo = 18'd0;
         hi = 18'd65536;
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            qpow = 176'd1;
            for (int i = 0; i < 5; i++) begin
               qpow = qpow * 176'(mid);
            end
            qpow = qpow * p255;
            if (qpow >= target) begin
               hi = mid;
            end else begin
               lo = mid + 18'd1;
            end
         end
         tab[v] = lo[THR_W-1:0];
      end
      return tab;
   endfunction

   localparam thresh_table_type GAMMA_THRESH = build_thresh();

endpackage

`default_nettype wire

[hdl/hdr_gamma_to_rgb8_flip.sv]
// Throughput: one pixel per clock unless rsp_stall holds; the path is set by the
// comparator bank of the channel encoders and the row-times-width multiply for
// the destination index. Accepted pixels pass the input, then the result stage.
// Reset (synchronous): clears both pipeline valids and the column and row counters,
// and sets width and height to one. No memory, so no clearing pass.
// Top level; uses hgr_pkg and hgr_gamma_enc.
`default_nettype none

module hdr_gamma_to_rgb8_flip #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [hgr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [hgr_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [hgr_pkg::LEVEL_W-1:0]       req_red_level,
   input  wire logic [hgr_pkg::LEVEL_W-1:0]       req_green_level,
   input  wire logic [hgr_pkg::LEVEL_W-1:0]       req_blue_level,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [hgr_pkg::CODE_W-1:0]        rsp_blue_byte,
   output logic      [hgr_pkg::CODE_W-1:0]        rsp_green_byte,
   output logic      [hgr_pkg::CODE_W-1:0]        rsp_red_byte,
   output logic      [hgr_pkg::DEST_OUT_W-1:0]    rsp_dest_pixel,
   output logic                                   rsp_frame_end
);
   import hgr_pkg::*;

   localparam int COL_W  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
   localparam int WEXT_W = CSR_DATA_W + WDIM_W;
   localparam int HEXT_W = CSR_DATA_W + HDIM_W;
   localparam int PROD_W = WDIM_W + HDIM_W + 1;
   localparam int DEST_W = (PROD_W > DEST_OUT_W) ? PROD_W : DEST_OUT_W;

   // size registers
   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic [WDIM_W-1:0]     width_eff;
   logic [HDIM_W-1:0]     height_eff;

   // raster counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             cfg_hit;
   logic             in_last_col;
   logic             in_last_row;

   // pipeline control
   logic adv1, adv2, req_take;

   // input stage
   logic                s1_valid_ff, s1_valid_in;
   logic [LEVEL_W-1:0]  s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic [ROW_W-1:0]    s1_row_ff;

   // work between the stages
   logic [CODE_W-1:0]   red_code, green_code, blue_code;
   logic [HDIM_W-1:0]   flip_row;
   logic [DEST_W-1:0]   dest_full;
   logic                s1_last;

   // result stage
   logic                  s2_valid_ff, s2_valid_in;
   logic [CODE_W-1:0]     s2_red_ff, s2_green_ff, s2_blue_ff;
   logic [DEST_OUT_W-1:0] s2_dest_ff;
   logic                  s2_last_ff;

   // clamp the programmed sizes to 1..MAX
   always_comb begin
      priority if (width_ff == '0) begin
         width_eff = WDIM_W'(1);
      end else if (WEXT_W'(width_ff) > WEXT_W'(MAX_WIDTH)) begin
         width_eff = WDIM_W'(MAX_WIDTH);
      end else begin
         width_eff = WDIM_W'(width_ff);
      end
      priority if (height_ff == '0) begin
         height_eff = HDIM_W'(1);
      end else if (HEXT_W'(height_ff) > HEXT_W'(MAX_HEIGHT)) begin
         height_eff = HDIM_W'(MAX_HEIGHT);
      end else begin
         height_eff = HDIM_W'(height_ff);
      end
   end

   // advance each stage when the one after it can take a word
   assign adv2      = !s2_valid_ff || !rsp_stall;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;
   assign req_take  = req_valid && adv1;

   // configuration writes to width or height restart the frame
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      cfg_hit   = 1'b0;
      if (csr_wr_en) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_in = csr_wr_data;
            cfg_hit  = 1'b1;
         end else if (csr_index == CSR_IMAGE_HEIGHT) begin
            height_in = csr_wr_data;
            cfg_hit   = 1'b1;
         end
      end
   end

   // step the raster counters on each accepted pixel
   assign in_last_col = (WDIM_W'(col_ff) + WDIM_W'(1)) >= width_eff;
   assign in_last_row = (HDIM_W'(row_ff) + HDIM_W'(1)) >= height_eff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (req_take) begin
         if (in_last_col) begin
            col_in = '0;
            row_in = in_last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign s1_valid_in = req_take || (s1_valid_ff && !adv2);
   assign s2_valid_in = (s1_valid_ff && adv2) || (s2_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= CSR_DATA_W'(1);
         height_ff   <= CSR_DATA_W'(1);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // capture the input word with its raster position
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_red_ff   <= req_red_level;
         s1_green_ff <= req_green_level;
         s1_blue_ff  <= req_blue_level;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
      end
   end

   // encode the three channels
   hgr_gamma_enc u_enc_red   (.level(s1_red_ff),   .code_out(red_code));
   hgr_gamma_enc u_enc_green (.level(s1_green_ff), .code_out(green_code));
   hgr_gamma_enc u_enc_blue  (.level(s1_blue_ff),  .code_out(blue_code));

   // flipped destination index and frame end flag
   assign flip_row  = height_eff - HDIM_W'(1) - HDIM_W'(s1_row_ff);
   assign dest_full = DEST_W'(flip_row) * DEST_W'(width_eff) + DEST_W'(s1_col_ff);
   assign s1_last   = ((WDIM_W'(s1_col_ff) + WDIM_W'(1)) >= width_eff)
                   && ((HDIM_W'(s1_row_ff) + HDIM_W'(1)) >= height_eff);

   // result register; hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (s1_valid_ff && adv2) begin
         s2_red_ff   <= red_code;
         s2_green_ff <= green_code;
         s2_blue_ff  <= blue_code;
         s2_dest_ff  <= dest_full[DEST_OUT_W-1:0];
         s2_last_ff  <= s1_last;
      end
   end

   assign rsp_valid      = s2_valid_ff;
   assign rsp_blue_byte  = s2_blue_ff;
   assign rsp_green_byte = s2_green_ff;
   assign rsp_red_byte   = s2_red_ff;
   assign rsp_dest_pixel = s2_dest_ff;
   assign rsp_frame_end  = s2_last_ff;

   // counters stay inside the frame
   a_counters_in_frame: assert property (@(posedge clock) disable iff (reset)
      (WDIM_W'(col_ff) < width_eff) && (HDIM_W'(row_ff) < height_eff))
      else $error("raster counter outside the frame");

   // an accepted pixel lands in the input stage
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted pixel lost");

   // last pixel of the frame maps to the end of the first destination row
   a_frame_end_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |->
         rsp_dest_pixel == DEST_OUT_W'(DEST_W'(width_eff) - DEST_W'(1)))
      else $error("frame end at wrong destination");

   // red at or above one saturates
   a_red_saturates: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && adv2 && (s1_red_ff[LEVEL_W-1:16] != '0) |=>
         rsp_red_byte == 8'hFF)
      else $error("red channel above one did not saturate");

endmodule

`default_nettype wire

[hdl/hgr_gamma_enc.sv]
// Gamma encoder for one channel: 8.16 radiance to byte, exponent 1/2.2, saturated.
// Uses the threshold table and formats of hgr_pkg.
`default_nettype none

module hgr_gamma_enc (
   input  wire logic [hgr_pkg::LEVEL_W-1:0] level,
   output logic      [hgr_pkg::CODE_W-1:0]  code_out
);
   import hgr_pkg::*;

   logic [THR_W-1:0] level_sat;
   logic [255:0]     therm;
   logic [7:0]       pos;
   logic [7:0]       cand;

   // clamp to 1.0; the top threshold is exactly 1.0, so this yields 255
   assign level_sat = (level[LEVEL_W-1:16] != '0) ? THR_W'(17'h10000)
                                                  : {1'b0, level[15:0]};

   // compare against every threshold; the result is a thermometer code
   always_comb begin
      therm[0] = 1'b1;
      for (int v = 1; v < 256; v++) begin
         therm[v] = (level_sat >= GAMMA_THRESH[v]);
      end
   end

   // count the ones by a binary search on the thermometer, one result bit at a time
   always_comb begin
      pos  = '0;
      cand = '0;
      for (int k = 7; k >= 0; k--) begin
         cand = pos | (8'd1 << k);
         if (therm[cand]) begin
            pos = cand;
         end
      end
   end

   assign code_out = pos;

endmodule

`default_nettype wire

[verif/hdr_gamma_to_rgb8_flip_tb.sv]
// Self-checking testbench for hdr_gamma_to_rgb8_flip: gamma encoding and flipped pixel index.
// A scoreboard class predicts each result word; plain tasks drive pixels and CSR writes.
// Depends on hgr_pkg and the hdr_gamma_to_rgb8_flip RTL.
`default_nettype none

module hdr_gamma_to_rgb8_flip_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hgr_pkg::*;

   localparam int FRAME_MAX_W = 4096;
   localparam int FRAME_MAX_H = 4096;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 6;

   // one expected result word
   typedef struct packed {
      logic [CODE_W-1:0]     blue;
      logic [CODE_W-1:0]     green;
      logic [CODE_W-1:0]     red;
      logic [DEST_OUT_W-1:0] dest;
      logic                  frame_end;
   } encoded_pixel_type;

   class pixel_scoreboard;
      int unsigned       width_reg;
      int unsigned       height_reg;
      int unsigned       column;
      int unsigned       row;
      int                errors;
      encoded_pixel_type pending_words[$];

      function new();
         width_reg  = 1;
         height_reg = 1;
         column     = 0;
         row        = 0;
         errors     = 0;
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      // clamp a size register into 1..cap
      function int unsigned clamp_size(int unsigned v, int unsigned cap);
         if (v < 1) return 1;
         if (v > cap) return cap;
         return v;
      endfunction

      // largest v with v^11 * 2^80 <= q^5 * 255^11; saturate at one and above
      function logic [CODE_W-1:0] gamma_byte(logic [LEVEL_W-1:0] level);
         logic [191:0] radiance;
         logic [191:0] code_pow;
         int           lo;
         int           hi;
         int           mid;
         if (level >= 24'h010000) return 8'd255;
         radiance = 192'd1;
         for (int i = 0; i < 5; i++) radiance = radiance * 192'(level[15:0]);
         for (int i = 0; i < 11; i++) radiance = radiance * 192'd255;
         lo = 0;
         hi = 255;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            code_pow = 192'd1;
            for (int i = 0; i < 11; i++) code_pow = code_pow * 192'(mid);
            code_pow = code_pow << 80;
            if (code_pow <= radiance) lo = mid;
            else hi = mid - 1;
         end
         return CODE_W'(lo);
      endfunction

      // any write to a known register restarts the frame
      function void write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_IMAGE_WIDTH) begin
            width_reg = 32'(data);
         end else if (index == CSR_IMAGE_HEIGHT) begin
            height_reg = 32'(data);
         end else begin
            return;
         end
         column = 0;
         row    = 0;
      endfunction

      function void note_pixel(logic [LEVEL_W-1:0] red, logic [LEVEL_W-1:0] green,
                               logic [LEVEL_W-1:0] blue);
         encoded_pixel_type word;
         int unsigned       w;
         int unsigned       h;
         bit                last_col;
         bit                last_row;
         w = clamp_size(width_reg, FRAME_MAX_W);
         h = clamp_size(height_reg, FRAME_MAX_H);
         word.blue      = gamma_byte(blue);
         word.green     = gamma_byte(green);
         word.red       = gamma_byte(red);
         word.dest      = DEST_OUT_W'((h - 1 - row) * w + column);
         last_col       = (column + 1 >= w);
         last_row       = (row + 1 >= h);
         word.frame_end = last_col && last_row;
         // advance raster position, wrap at frame end
         if (last_col) begin
            column = 0;
            row    = last_row ? 0 : row + 1;
         end else begin
            column++;
         end
         pending_words.push_back(word);
      endfunction

      task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %0h want %0h", field, got, want);
         errors++;
      endtask

      task check_word(encoded_pixel_type got);
         encoded_pixel_type want;
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected word", 32'(got), 32'd0);
            return;
         end
         want = pending_words.pop_front();
         if (got.blue != want.blue)
            report_mismatch("blue_byte", 32'(got.blue), 32'(want.blue));
         if (got.green != want.green)
            report_mismatch("green_byte", 32'(got.green), 32'(want.green));
         if (got.red != want.red)
            report_mismatch("red_byte", 32'(got.red), 32'(want.red));
         if (got.dest != want.dest)
            report_mismatch("dest_pixel", 32'(got.dest), 32'(want.dest));
         if (got.frame_end != want.frame_end)
            report_mismatch("frame_end", 32'(got.frame_end), 32'(want.frame_end));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [LEVEL_W-1:0]     req_red_level = '0;
   logic [LEVEL_W-1:0]     req_green_level = '0;
   logic [LEVEL_W-1:0]     req_blue_level = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CODE_W-1:0]      rsp_blue_byte;
   logic [CODE_W-1:0]      rsp_green_byte;
   logic [CODE_W-1:0]      rsp_red_byte;
   logic [DEST_OUT_W-1:0]  rsp_dest_pixel;
   logic                   rsp_frame_end;

   logic                   calm = 1'b0;
   int                     cycles = 0;
   pixel_scoreboard        sb = new();

   hdr_gamma_to_rgb8_flip #(
      .MAX_WIDTH  (FRAME_MAX_W),
      .MAX_HEIGHT (FRAME_MAX_H)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_red_level   (req_red_level),
      .req_green_level (req_green_level),
      .req_blue_level  (req_blue_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_blue_byte   (rsp_blue_byte),
      .rsp_green_byte  (rsp_green_byte),
      .rsp_red_byte    (rsp_red_byte),
      .rsp_dest_pixel  (rsp_dest_pixel),
      .rsp_frame_end   (rsp_frame_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stall the result side at random, never during a calm stretch
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 38);
   end

   // check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_word({rsp_blue_byte, rsp_green_byte, rsp_red_byte, rsp_dest_pixel,
                        rsp_frame_end});
      end
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // drive one pixel word and hold it until accepted
   task send_pixel(logic [LEVEL_W-1:0] red, logic [LEVEL_W-1:0] green,
                   logic [LEVEL_W-1:0] blue);
      while (!calm && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_red_level   <= red;
      req_green_level <= green;
      req_blue_level  <= blue;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pixel(red, green, blue);
   endtask

   // drop valid and wait until every expected word is back
   task drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task csr_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      sb.write_csr(index, data);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function logic [LEVEL_W-1:0] random_level();
      case ($urandom_range(9))
         0: return '0;
         1: return 24'h00FFFF;
         2: return 24'h010000 + LEVEL_W'($urandom_range(3));
         3: return LEVEL_W'($urandom_range(255));
         4, 5: return LEVEL_W'($urandom);
         default: return LEVEL_W'($urandom_range(16'hFFFF));
      endcase
   endfunction

   task send_random(int count);
      for (int i = 0; i < count; i++) begin
         send_pixel(random_level(), random_level(), random_level());
      end
   endtask

   // one frame setting, optionally with an ignored write in the middle
   task run_phase(int unsigned w, int unsigned h, int count, bit quiet);
      drain();
      if ($urandom_range(1)) begin
         csr_write(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
         csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      end else begin
         csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
         csr_write(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      end
      calm <= quiet;
      send_random(count / 2);
      if ($urandom_range(1)) begin
         drain();
         csr_write(CSR_INDEX_W'($urandom_range(15, 2)), CSR_DATA_W'($urandom));
      end
      send_random(count - count / 2);
      calm <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset size is 1x1: every pixel ends a frame; channel extremes
      send_pixel(24'h000000, 24'h000000, 24'h000000);
      send_pixel(24'h00FFFF, 24'h010000, 24'hFFFFFF);
      send_pixel(24'h000001, 24'h000002, 24'h008000);
      send_pixel(24'hFFFFFF, 24'h000000, 24'h00FFFF);

      // full 3x2 frame, then wrap
      drain();
      csr_write(CSR_IMAGE_WIDTH, 13'd3);
      csr_write(CSR_IMAGE_HEIGHT, 13'd2);
      send_pixel(24'h000010, 24'h000100, 24'h001000);
      send_pixel(24'h004000, 24'h00C000, 24'h00FFFE);
      send_pixel(24'h800000, 24'h0000FF, 24'h000003);
      send_pixel(24'h0F0F0F, 24'hF0F0F0, 24'h555555);
      send_pixel(24'hAAAAAA, 24'h00AAAA, 24'h005555);
      send_pixel(24'h000000, 24'h00FFFF, 24'h010000);
      send_pixel(24'h000007, 24'h000070, 24'h000700);

      // an unknown index leaves the position alone; a known one restarts it
      drain();
      csr_write(CSR_INDEX_W'(5), 13'h1FFF);
      send_pixel(24'h007000, 24'h070000, 24'h700000);
      drain();
      csr_write(CSR_IMAGE_WIDTH, 13'd3);
      send_pixel(24'h001234, 24'h00ABCD, 24'h00FEDC);
      send_pixel(24'h00F000, 24'h000F00, 24'h0000F0);

      // zero sizes count as one
      drain();
      csr_write(CSR_IMAGE_WIDTH, 13'd0);
      csr_write(CSR_IMAGE_HEIGHT, 13'd0);
      send_pixel(24'h00FFFF, 24'h00FFFF, 24'h00FFFF);
      send_pixel(24'h000001, 24'h000001, 24'h000001);

      // oversized sizes clamp to the maximum
      drain();
      csr_write(CSR_IMAGE_WIDTH, 13'h1FFF);
      csr_write(CSR_IMAGE_HEIGHT, 13'h1FFF);
      send_pixel(24'h000000, 24'hFFFFFF, 24'h00FFFF);
      send_pixel(24'h000080, 24'h008080, 24'h808080);
      send_pixel(24'h00FFFF, 24'h000000, 24'h000001);

      // random part: extremes first, then mostly small frames that wrap often
      run_phase(1, 1, 60, 1'b0);
      run_phase(4096, 4096, 40, 1'b0);
      run_phase(0, 0, 40, 1'b0);
      run_phase(8191, 8191, 30, 1'b0);
      run_phase(4097, 2, 30, 1'b0);
      run_phase(1, 4096, 30, 1'b0);
      for (int p = 0; p < 11; p++) begin
         if (p == 2) begin
            run_phase($urandom_range(16, 1), $urandom_range(16, 1), 220, 1'b1);
         end else begin
            run_phase($urandom_range(16, 1), $urandom_range(16, 1),
                      $urandom_range(120, 60), 1'b0);
         end
      end
      run_phase($urandom_range(8191, 1), $urandom_range(8191, 1), 40, 1'b0);
      run_phase($urandom_range(64, 17), $urandom_range(8, 1), 120, 1'b0);

      drain();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

[hdr_gamma_to_rgb8_flip.f]
hdl/hgr_pkg.sv
hdl/hgr_gamma_enc.sv
hdl/hdr_gamma_to_rgb8_flip.sv
verif/hdr_gamma_to_rgb8_flip_tb.sv
